// ----- hdl/lcps_pkg.sv -----
package lcps_pkg;

    localparam int PIXEL_W = 8;
    localparam int LOG_W   = 20;
    localparam int NUM_W   = LOG_W + PIXEL_W;
    localparam int FRAC_W  = 16;
    localparam int GUARD_W = 8;
    localparam int STEP_W  = 3;

    localparam logic [PIXEL_W-1:0] FULL_SCALE = 8'd255;

    typedef logic [LOG_W-1:0] log_rom_t [256];

    // datapath commands issued by the controller
    typedef struct packed {
        logic measure;
        logic capture;
        logic lookup;
        logic divide;
        logic deliver;
    } lcps_cmd_t;

    // (a*a) >> 62 kept to 64 bits, built from 32-bit partial products
    function automatic logic [63:0] square_q62(input logic [63:0] a);
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] hh;
        logic [63:0] hl2;
        logic [63:0] ll;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] carry;
        ah    = a >> 32;
        al    = a & 64'h0000_0000_FFFF_FFFF;
        hh    = ah * ah;
        hl2   = (ah * al) << 1;
        ll    = al * al;
        lo    = ll + (hl2 << 32);
        carry = (lo < ll) ? 64'd1 : 64'd0;
        hi    = hh + (hl2 >> 32) + carry;
        return (hi << 2) | (lo >> 62);
    endfunction

    // round(65536 * log2(1 + v*v)) by repeated squaring of the mantissa
    function automatic logic [LOG_W-1:0] log_entry(input int v);
        logic [31:0] x;
        logic [31:0] e;
        logic [63:0] m;
        logic [31:0] frac;
        logic [31:0] sum;
        x    = 32'd1 + 32'(v) * 32'(v);
        e    = 32'd0;
        frac = 32'd0;
        for (int k = 0; k < 31; k++)
        begin
            if ((x >> (k + 1)) != 32'd0)
            begin
                e = 32'(k + 1);
            end
        end
        m = 64'(x) << (32'd62 - e);
        for (int i = 0; i < FRAC_W + GUARD_W; i++)
        begin
            m    = square_q62(m);
            frac = frac << 1;
            if (m[63])
            begin
                frac = frac | 32'd1;
                m    = m >> 1;
            end
        end
        sum = (e << FRAC_W) + ((frac + (32'd1 << (GUARD_W - 1))) >> GUARD_W);
        return sum[LOG_W-1:0];
    endfunction

    function automatic log_rom_t build_log_rom();
        log_rom_t rom;
        for (int v = 0; v < 256; v++)
        begin
            rom[v] = log_entry(v);
        end
        return rom;
    endfunction

    localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

// ----- hdl/lcps_ctrl.sv -----
module lcps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              command,
    output logic              result_valid,
    input  logic              result_ready,
    output lcps_pkg::lcps_cmd_t cmd
);
    import lcps_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        LOOKUP,
        DIVIDE,
        DELIVER
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              accept;
    logic              can_load;

    assign item_ready   = (state_reg == IDLE);
    assign result_valid = out_valid_reg;
    assign accept       = item_valid && item_ready;
    assign can_load     = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd            = '0;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    if (command)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = LOOKUP;
                    end
                    else
                    begin
                        cmd.measure = 1'b1;
                    end
                end
            end
            LOOKUP:
            begin
                cmd.lookup = 1'b1;
                step_next  = '1;
                state_next = DIVIDE;
            end
            DIVIDE:
            begin
                cmd.divide = 1'b1;
                step_next  = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = DELIVER;
                end
            end
            DELIVER:
            begin
                if (can_load)
                begin
                    cmd.deliver    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hdl/lcps_datapath.sv -----
module lcps_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lcps_pkg::lcps_cmd_t          cmd,
    input  logic [lcps_pkg::PIXEL_W-1:0] pixel,
    input  logic                         start_of_frame,
    output logic [lcps_pkg::PIXEL_W-1:0] scaled_pixel
);
    import lcps_pkg::*;

    logic [PIXEL_W-1:0] max_reg;
    logic [PIXEL_W-1:0] max_next;
    logic [PIXEL_W-1:0] pix_reg;
    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   rem_next;
    logic [NUM_W-1:0]   dsor_reg;
    logic [PIXEL_W-1:0] quo_reg;
    logic               zero_reg;
    logic               sat_reg;
    logic [PIXEL_W-1:0] out_reg;
    logic [PIXEL_W-1:0] out_next;
    logic [LOG_W-1:0]   log_pix;
    logic [LOG_W-1:0]   log_max;
    logic [NUM_W-1:0]   num;
    logic               ge;

    assign log_pix = LOG_ROM[pix_reg];
    assign log_max = LOG_ROM[max_reg];

    // 255 * L(p) as a shift and subtract
    assign num = {log_pix, {PIXEL_W{1'b0}}} - NUM_W'(log_pix);

    assign ge       = (rem_reg >= dsor_reg);
    assign rem_next = ge ? (rem_reg - dsor_reg) : rem_reg;

    always_comb
    begin
        max_next = max_reg;
        if (start_of_frame || (pixel > max_reg))
        begin
            max_next = pixel;
        end
    end

    always_comb
    begin
        if (zero_reg)
        begin
            out_next = '0;
        end
        else if (sat_reg)
        begin
            out_next = FULL_SCALE;
        end
        else
        begin
            out_next = quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
        end
        else if (cmd.measure)
        begin
            max_reg <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg <= pixel;
        end
        if (cmd.lookup)
        begin
            rem_reg  <= num;
            dsor_reg <= {1'b0, log_max, {(PIXEL_W-1){1'b0}}};
            zero_reg <= (max_reg == '0);
            sat_reg  <= (pix_reg > max_reg);
        end
        if (cmd.divide)
        begin
            rem_reg  <= rem_next;
            dsor_reg <= dsor_reg >> 1;
            quo_reg  <= {quo_reg[PIXEL_W-2:0], ge};
        end
        if (cmd.deliver)
        begin
            out_reg <= out_next;
        end
    end

    assign scaled_pixel = out_reg;

endmodule

// ----- hdl/log_contrast_pixel_scaler.sv -----
// Two-pass logarithmic contrast stretch for 8-bit grey pixels. The host sends
// each frame twice: first as measure transactions (command 0), which build a
// running frame maximum, restarted from the pixel when start_of_frame is set;
// then as scale transactions (command 1), each returning one result
// floor(255 * L(p) / L(max)) with L(v) = log2(1 + v*v) in fixed point with
// 16 fraction bits. A zero maximum gives 0, a pixel above the maximum gives
// 255. A measure transaction produces nothing; a scale transaction steps through
// a lookup, eight restoring divide steps of one quotient bit per cycle, and
// an output load, and the next transaction is accepted only after that output
// load. The output register lets the next transaction be accepted while a
// result waits to be taken; a following scale transaction then holds in its
// output load step until that result is taken.
module log_contrast_pixel_scaler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         command,
    input  logic [lcps_pkg::PIXEL_W-1:0] pixel,
    input  logic                         start_of_frame,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [lcps_pkg::PIXEL_W-1:0] scaled_pixel
);
    import lcps_pkg::*;

    // command bundle from the controller to the datapath
    lcps_cmd_t cmd;

    // sequencer: handshakes, divide step count, output valid
    lcps_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    // frame maximum, log table lookup, serial divider and output register
    lcps_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .pixel          (pixel),
        .start_of_frame (start_of_frame),
        .scaled_pixel   (scaled_pixel)
    );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    // command codes carried by one input transaction
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_SCALE   = 1'b1;

    localparam int PW            = lcps_pkg::PIXEL_W;
    localparam int TOTAL_ITEMS   = 1450;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int REPORT_LIMIT  = 10;
    localparam int NUM_DIRECTED  = 25;

    // one row of the directed table; known marks a result typed in by hand
    typedef struct packed {
        logic          command;
        logic [PW-1:0] pixel;
        logic          start;
        logic          known;
        logic [PW-1:0] scaled;
    } directed_row_t;

    localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
        // scale before any measure: maximum is still zero after reset
        '{CMD_SCALE,   8'd0,   1'b0, 1'b1, 8'd0},
        '{CMD_SCALE,   8'd255, 1'b1, 1'b1, 8'd0},
        // restart the frame from a black pixel, maximum stays zero
        '{CMD_MEASURE, 8'd0,   1'b1, 1'b0, 8'd0},
        '{CMD_SCALE,   8'd200, 1'b0, 1'b1, 8'd0},
        // full-range frame
        '{CMD_MEASURE, 8'd255, 1'b0, 1'b0, 8'd0},
        '{CMD_SCALE,   8'd255, 1'b0, 1'b1, 8'd255},
        '{CMD_SCALE,   8'd0,   1'b0, 1'b1, 8'd0},
        '{CMD_SCALE,   8'd128, 1'b0, 1'b0, 8'd0},
        // start flag on a scale transaction has no effect
        '{CMD_SCALE,   8'd254, 1'b1, 1'b0, 8'd0},
        // smallest non-zero maximum, pixels above it saturate
        '{CMD_MEASURE, 8'd1,   1'b1, 1'b0, 8'd0},
        '{CMD_SCALE,   8'd1,   1'b0, 1'b1, 8'd255},
        '{CMD_SCALE,   8'd2,   1'b0, 1'b1, 8'd255},
        '{CMD_SCALE,   8'd0,   1'b1, 1'b1, 8'd0},
        // running maximum grows but never shrinks without the start flag
        '{CMD_MEASURE, 8'd100, 1'b0, 1'b0, 8'd0},
        '{CMD_MEASURE, 8'd50,  1'b0, 1'b0, 8'd0},
        '{CMD_SCALE,   8'd100, 1'b0, 1'b1, 8'd255},
        '{CMD_SCALE,   8'd50,  1'b0, 1'b0, 8'd0},
        '{CMD_SCALE,   8'd101, 1'b0, 1'b1, 8'd255},
        // start flag may pull the maximum down
        '{CMD_MEASURE, 8'd170, 1'b1, 1'b0, 8'd0},
        '{CMD_SCALE,   8'd85,  1'b0, 1'b0, 8'd0},
        '{CMD_SCALE,   8'd169, 1'b0, 1'b0, 8'd0},
        '{CMD_MEASURE, 8'd0,   1'b1, 1'b0, 8'd0},
        '{CMD_SCALE,   8'd170, 1'b0, 1'b1, 8'd0},
        '{CMD_MEASURE, 8'd85,  1'b0, 1'b0, 8'd0},
        '{CMD_SCALE,   8'd170, 1'b1, 1'b1, 8'd255}
    };

    logic          clk = 1'b0;
    logic          rst_n;
    logic          item_valid;
    logic          item_ready;
    logic          command;
    logic [PW-1:0] pixel;
    logic          start_of_frame;
    logic          result_valid;
    logic          result_ready = 1'b0;
    logic [PW-1:0] scaled_pixel;

    // predictor state: log table and the running frame maximum
    logic [lcps_pkg::LOG_W-1:0] log_lut [256];
    logic [PW-1:0]              frame_peak;

    logic [PW-1:0] expected_pixels [$];
    int            mismatches;
    int            items_sent;
    int            cycle_count;
    int            sender_idle_pct;
    int            receiver_idle_pct;

    log_contrast_pixel_scaler u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .command        (command),
        .pixel          (pixel),
        .start_of_frame (start_of_frame),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .scaled_pixel   (scaled_pixel)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // round(65536 * log2(1 + v*v)): integer part from the leading one, then
    // 24 fraction bits by squaring the normalised mantissa, rounded to 16
    function automatic logic [lcps_pkg::LOG_W-1:0] log2_fixed(input int unsigned v);
        logic [31:0]  arg;
        int unsigned  whole;
        logic [63:0]  mant;
        logic [127:0] sq;
        logic [31:0]  bits;
        logic [31:0]  sum;
        arg   = 32'd1 + v * v;
        whole = 0;
        while ((arg >> (whole + 1)) != 32'd0)
        begin
            whole++;
        end
        mant = 64'(arg) << (62 - whole);
        bits = 32'd0;
        repeat (lcps_pkg::FRAC_W + lcps_pkg::GUARD_W)
        begin
            sq   = {64'd0, mant} * {64'd0, mant};
            mant = sq[125:62];
            bits = bits << 1;
            if (mant[63])
            begin
                bits = bits | 32'd1;
                mant = mant >> 1;
            end
        end
        sum = (32'(whole) << lcps_pkg::FRAC_W)
            + ((bits + (32'd1 << (lcps_pkg::GUARD_W - 1))) >> lcps_pkg::GUARD_W);
        return sum[lcps_pkg::LOG_W-1:0];
    endfunction

    // expected stretch of one pixel against the current frame maximum
    function automatic logic [PW-1:0] stretch_pixel(input logic [PW-1:0] p);
        logic [31:0] num;
        logic [31:0] den;
        if (frame_peak == '0)
        begin
            return '0;
        end
        if (p > frame_peak)
        begin
            return lcps_pkg::FULL_SCALE;
        end
        num = 32'(lcps_pkg::FULL_SCALE) * 32'(log_lut[p]);
        den = 32'(log_lut[frame_peak]);
        num = num / den;
        if (num > 32'(lcps_pkg::FULL_SCALE))
        begin
            num = 32'(lcps_pkg::FULL_SCALE);
        end
        return num[PW-1:0];
    endfunction

    task automatic note_failure(input string what, input logic [PW-1:0] want,
                                input logic [PW-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
        end
    endtask

    // one input transaction: random gap, hold until accepted, then update
    // the predictor; entered and left at a falling edge
    task automatic send_item(input logic cmd, input logic [PW-1:0] pix,
                             input logic sof, input logic known,
                             input logic [PW-1:0] known_value);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid     <= 1'b1;
        command        <= cmd;
        pixel          <= pix;
        start_of_frame <= sof;
        do
        begin
            @(posedge clk);
        end
        while (!item_ready);
        items_sent++;
        if (cmd == CMD_MEASURE)
        begin
            if (sof || pix > frame_peak)
            begin
                frame_peak = pix;
            end
        end
        else if (known)
        begin
            expected_pixels.push_back(known_value);
        end
        else
        begin
            expected_pixels.push_back(stretch_pixel(pix));
        end
        @(negedge clk);
    endtask

    // random pixel for a frame: full range, a narrow band, or a dark frame
    function automatic logic [PW-1:0] frame_pixel(input int style,
                                                   input logic [PW-1:0] base);
        case (style)
            0: return PW'($urandom_range(0, 255));
            1: return base + PW'($urandom_range(0, 15));
            default: return PW'($urandom_range(0, 3));
        endcase
    endfunction

    // a frame sent twice: measure pass then scale pass; some frames are
    // broken (no start flag, stray pixels, partial scale pass) or plain noise
    task automatic stream_frame();
        logic [PW-1:0] frame_pixels [$];
        logic [PW-1:0] base;
        int            count;
        int            style;
        int            flavour;
        style   = $urandom_range(0, 2);
        base    = PW'($urandom_range(0, 255));
        flavour = $urandom_range(0, 99);
        count   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48)
                                              : $urandom_range(1, 12);
        if (flavour < 10)
        begin
            // noise: every field random
            repeat ($urandom_range(1, 8))
            begin
                send_item(1'($urandom_range(0, 1)), PW'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0, '0);
            end
            return;
        end
        for (int i = 0; i < count; i++)
        begin
            frame_pixels.push_back(frame_pixel(style, base));
        end
        for (int i = 0; i < count; i++)
        begin
            // a frame without its start flag continues from the old maximum
            send_item(CMD_MEASURE, frame_pixels[i], (i == 0) && (flavour >= 20),
                      1'b0, '0);
        end
        for (int i = 0; i < count; i++)
        begin
            if (flavour >= 90 && i > count / 2)
            begin
                break;
            end
            if (flavour >= 80 && flavour < 90 && $urandom_range(0, 3) == 0)
            begin
                send_item(CMD_SCALE, PW'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0, '0);
            end
            send_item(CMD_SCALE, frame_pixels[i], 1'($urandom_range(0, 1)),
                      1'b0, '0);
        end
    endtask

    // output side: random back-pressure, driven at the falling edge
    always @(negedge clk)
    begin
        result_ready <= rst_n && ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // result checker, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                note_failure("unexpected result", '0, scaled_pixel);
            end
            else if (scaled_pixel !== expected_pixels[0])
            begin
                note_failure("scaled_pixel", expected_pixels[0], scaled_pixel);
                void'(expected_pixels.pop_front());
            end
            else
            begin
                void'(expected_pixels.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int new_phase;
        rst_n             = 1'b0;
        item_valid        = 1'b0;
        command           = CMD_MEASURE;
        pixel             = '0;
        start_of_frame    = 1'b0;
        mismatches        = 0;
        items_sent        = 0;
        cycle_count       = 0;
        frame_peak        = '0;
        sender_idle_pct   = 35;
        receiver_idle_pct = 82;
        phase             = 0;
        for (int v = 0; v < 256; v++)
        begin
            log_lut[v] = log2_fixed(v);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            send_item(DIRECTED[r].command, DIRECTED[r].pixel, DIRECTED[r].start,
                      DIRECTED[r].known, DIRECTED[r].scaled);
        end

        // random frames, idling pattern changes by thirds
        while (items_sent < TOTAL_ITEMS)
        begin
            new_phase = (items_sent * 3) / TOTAL_ITEMS;
            if (new_phase != phase)
            begin
                phase = new_phase;
                // hold the sender off until every pending result is out
                item_valid <= 1'b0;
                while (expected_pixels.size() != 0)
                begin
                    @(negedge clk);
                end
                @(negedge clk);
                sender_idle_pct   = (phase == 1) ? 82 : 0;
                receiver_idle_pct = (phase == 1) ? 35 : 0;
            end
            stream_frame();
        end
        item_valid <= 1'b0;

        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_pixels.size() != 0)
        begin
            note_failure("missing result", expected_pixels[0], '0);
        end
        if (mismatches == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/lcps_pkg.sv
hdl/lcps_ctrl.sv
hdl/lcps_datapath.sv
hdl/log_contrast_pixel_scaler.sv
tb/tb_top.sv
